>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types, codes and default sizes of the fixed priority assigner
// ----------------------------------------------------------------------------

package fpa_pkg;

    // default sizes
    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_BITS_DEF = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PRIO_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_PRIO = 2'd1;

    localparam logic              POLICY_RST   = 1'b0;
    localparam logic [PRIO_W-1:0] TOP_PRIO_RST = 8'd7;

    // command codes
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_ASSIGN = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ADD_ACK = 2'd0,
        KIND_ASSIGN  = 2'd1,
        KIND_EMPTY   = 2'd2
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EMIT = 2'd2
    } t_state;

endpackage

>>> rtl/fixed_priority_assigner_core.sv
// ----------------------------------------------------------------------------
// fixed_priority_assigner_core
// rate / deadline monotonic priority assignment over a table of tasks
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. An add stores a
// task's period and deadline in the next free slot and answers one result in
// the following cycle; busy stays low, so adds can come every cycle. A clear
// gives no result. An assign with n stored tasks keeps busy high until its
// last result is emitted: for each of the n results the task ram is scanned
// once through its single read port, the registered read data is compared,
// and then the emit state gives the result. Results appear on o_valid for
// exactly one cycle each and cannot be held off, so the receiver must take
// every transfer as it comes. An assign on an empty table answers a single
// result of kind empty. Configuration writes are always ready.
// ----------------------------------------------------------------------------

module fixed_priority_assigner_core #(
    parameter int MAX_TASKS = fpa_pkg::MAX_TASKS_DEF,
    parameter int TICK_BITS = fpa_pkg::TICK_BITS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // command
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic [TICK_BITS-1:0]          i_period,
    input  logic [TICK_BITS-1:0]          i_deadline,

    // results, one cycle each
    output logic                          o_valid,
    output logic [1:0]                    o_kind,
    output logic [IDX_W-1:0]              o_task_slot,
    output logic [fpa_pkg::PRIO_W-1:0]    o_priority_res,
    output logic [TICK_BITS-1:0]          o_sort_key,
    output logic                          o_priority_error,
    output logic                          o_table_full,
    output logic                          o_last
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int PW    = fpa_pkg::PRIO_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    // configuration registers
    logic          r_policy;
    logic [PW-1:0] r_top_prio;

    // control state
    fpa_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_scan, n_scan;      // next slot to read
    logic [CNT_W-1:0]     r_iter, n_iter;      // results emitted so far
    logic                 r_pend_v, n_pend_v;  // read data valid this cycle
    logic [IDX_W-1:0]     r_pend_slot, n_pend_slot;
    logic [MAX_TASKS-1:0] r_assigned, n_assigned;

    // search state
    logic [TICK_BITS-1:0] r_best, n_best;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [TICK_BITS-1:0] r_prev_key, n_prev_key;
    logic [PW-1:0]        r_prio, n_prio;

    // result registers
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_kind, n_out_kind;
    logic [IDX_W-1:0]     r_out_slot, n_out_slot;
    logic [PW-1:0]        r_out_prio, n_out_prio;
    logic [TICK_BITS-1:0] r_out_key, n_out_key;
    logic                 r_out_perr, n_out_perr;
    logic                 r_out_full, n_out_full;
    logic                 r_out_last, n_out_last;

    // ram side
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [2*TICK_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [2*TICK_BITS-1:0] ram_rdata;

    logic                 accept;
    fpa_pkg::t_func       func;
    logic [TICK_BITS-1:0] rd_key;
    logic                 take;
    logic [PW-1:0]        emit_prio;

    assign accept = start && !busy;
    assign func   = fpa_pkg::t_func'(i_func);

    // period in the low half, deadline in the high half
    assign rd_key = r_policy ? ram_rdata[2*TICK_BITS-1:TICK_BITS] : ram_rdata[TICK_BITS-1:0];

    // candidate wins on less-or-equal, so the highest slot wins a tie
    assign take = r_pend_v && !r_assigned[r_pend_slot] && (rd_key <= r_best);

    // priority drops on every key change and saturates at idle
    assign emit_prio = ((r_best != r_prev_key) && (r_prio != '0)) ? r_prio - 1'b1 : r_prio;

    assign ram_we    = accept && (func == fpa_pkg::FUNC_ADD) && (r_count < MAX_CNT);
    assign ram_waddr = r_count[IDX_W-1:0];
    assign ram_wdata = {i_deadline, i_period};
    assign ram_raddr = r_scan[IDX_W-1:0];

    fpa_ram #(
        .WIDTH (2 * TICK_BITS),
        .DEPTH (MAX_TASKS),
        .ADDR_W(IDX_W)
    ) u_task_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= fpa_pkg::POLICY_RST;
            r_top_prio <= fpa_pkg::TOP_PRIO_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpa_pkg::CFG_POLICY:   r_policy   <= i_cfg_data[0];
                fpa_pkg::CFG_TOP_PRIO: r_top_prio <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpa_pkg::S_IDLE: begin
                if (accept && (func == fpa_pkg::FUNC_ASSIGN) && (r_count != '0)) begin
                    n_state = fpa_pkg::S_SCAN;
                end
            end
            fpa_pkg::S_SCAN: begin
                // last read data is compared in this cycle
                if (r_scan == r_count) begin
                    n_state = fpa_pkg::S_EMIT;
                end
            end
            fpa_pkg::S_EMIT: begin
                if (r_iter + 1'b1 == r_count) begin
                    n_state = fpa_pkg::S_IDLE;
                end else begin
                    n_state = fpa_pkg::S_SCAN;
                end
            end
            default: n_state = fpa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_scan      = r_scan;
        n_iter      = r_iter;
        n_pend_v    = 1'b0;
        n_pend_slot = r_scan[IDX_W-1:0];
        n_assigned  = r_assigned;
        n_best      = r_best;
        n_pick      = r_pick;
        n_prev_key  = r_prev_key;
        n_prio      = r_prio;
        n_out_valid = 1'b0;
        n_out_kind  = fpa_pkg::KIND_ADD_ACK;
        n_out_slot  = '0;
        n_out_prio  = '0;
        n_out_key   = '0;
        n_out_perr  = 1'b0;
        n_out_full  = 1'b0;
        n_out_last  = 1'b1;

        // compare the slot read in the previous cycle
        if (take) begin
            n_best = rd_key;
            n_pick = r_pend_slot;
        end

        unique case (r_state)
            fpa_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (func)
                        fpa_pkg::FUNC_ADD: begin
                            n_out_valid = 1'b1;
                            if (r_count < MAX_CNT) begin
                                n_out_slot = r_count[IDX_W-1:0];
                                n_assigned[r_count[IDX_W-1:0]] = 1'b0;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out_full = 1'b1;
                            end
                        end
                        fpa_pkg::FUNC_ASSIGN: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = fpa_pkg::KIND_EMPTY;
                            end else begin
                                n_assigned = '0;
                                n_prev_key = '0;
                                n_prio     = r_top_prio;
                                n_best     = '1;
                                n_pick     = '0;
                                n_scan     = '0;
                                n_iter     = '0;
                            end
                        end
                        fpa_pkg::FUNC_CLEAR: begin
                            n_count    = '0;
                            n_assigned = '0;
                        end
                        default: ;
                    endcase
                end
            end
            fpa_pkg::S_SCAN: begin
                if (r_scan != r_count) begin
                    n_pend_v = 1'b1;
                    n_scan   = r_scan + 1'b1;
                end
            end
            fpa_pkg::S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_kind  = fpa_pkg::KIND_ASSIGN;
                n_out_slot  = r_pick;
                n_out_prio  = emit_prio;
                n_out_key   = r_best;
                n_out_perr  = (emit_prio == '0);
                n_out_last  = (r_iter + 1'b1 == r_count);
                n_assigned[r_pick] = 1'b1;
                n_prev_key  = r_best;
                n_prio      = emit_prio;
                n_iter      = r_iter + 1'b1;
                // fresh search for the next result
                n_best      = '1;
                n_pick      = '0;
                n_scan      = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpa_pkg::S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_iter      <= '0;
            r_pend_v    <= 1'b0;
            r_assigned  <= '0;
            r_prev_key  <= '0;
            r_prio      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_iter      <= n_iter;
            r_pend_v    <= n_pend_v;
            r_assigned  <= n_assigned;
            r_prev_key  <= n_prev_key;
            r_prio      <= n_prio;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_best      <= n_best;
        r_pick      <= n_pick;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_prio  <= n_out_prio;
        r_out_key   <= n_out_key;
        r_out_perr  <= n_out_perr;
        r_out_full  <= n_out_full;
        r_out_last  <= n_out_last;
    end

    assign busy             = (r_state != fpa_pkg::S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_task_slot      = r_out_slot;
    assign o_priority_res   = r_out_prio;
    assign o_sort_key       = r_out_key;
    assign o_priority_error = r_out_perr;
    assign o_table_full     = r_out_full;
    assign o_last           = r_out_last;

    // table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("task count beyond table depth");

    // scan pointer stays within the stored tasks
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpa_pkg::S_SCAN) |-> (r_scan <= r_count))
        else $error("scan pointer past task count");

    // every emit cycle yields exactly one result transfer
    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpa_pkg::S_EMIT) |=> (o_valid && (o_kind == fpa_pkg::KIND_ASSIGN)))
        else $error("emit cycle without assignment result");

    // a non-empty assign makes the block busy
    a_assign_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (func == fpa_pkg::FUNC_ASSIGN) && (r_count != '0)) |=> busy)
        else $error("assign did not start the scan");

    // the final assignment releases the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && (o_kind == fpa_pkg::KIND_ASSIGN)) |-> !busy)
        else $error("busy after final assignment");

endmodule

>>> rtl/fpa_ram.sv
// ----------------------------------------------------------------------------
// fpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------

module fpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/fixed_priority_assigner_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_priority_assigner_core_test
// Self-checking bench for the rate / deadline monotonic priority assigner.
// The bench starts with a short table of directed commands: the empty table,
// extreme keys, a full table, priorities that fall to idle, both policies and
// both ends of the top priority range. A random run follows, mostly in
// well-formed clear / add / assign sequences with some noise mixed in. Each
// result is compared field by field with the oldest entry of a queue that an
// in-bench priority calculator or a typed row of the directed table fills.
// ----------------------------------------------------------------------------

module fixed_priority_assigner_core_test;
    import fpa_pkg::*;

    localparam int N_TASKS       = MAX_TASKS_DEF;
    localparam int KEY_W         = TICK_BITS_DEF;
    localparam int SLOT_W        = $clog2(N_TASKS);
    localparam int RANDOM_ITEMS  = 168;
    localparam int SETTLE_CYCLES = 8;     // clear and ignored codes finish silently
    localparam int TAIL_CYCLES   = 40;
    // even a full 16 task assign leaves far shorter gaps between results, so
    // this is many times the longest quiet stretch of a correct run
    localparam int STALL_LIMIT   = 4000;

    localparam logic [1:0]       FUNC_UNUSED = 2'd3;    // not decoded by the block
    localparam logic [KEY_W-1:0] KEY_MAX     = '1;

    // one result transfer
    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]  key;
        logic              perr;
        logic              full;
        logic              last;
    } t_prio_result;

    typedef enum logic { ROW_CMD, ROW_CFG } t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [1:0]            func;
        logic [KEY_W-1:0]      period;
        logic [KEY_W-1:0]      deadline;
        logic [5:0]            reps;
        logic                  rnd_keys;   // fresh random keys on every repeat
        logic                  typed;      // expectation written into the table
        t_prio_result          want;
    } t_plan_row;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  start       = 1'b0;
    logic [1:0]            i_func      = '0;
    logic [KEY_W-1:0]      i_period    = '0;
    logic [KEY_W-1:0]      i_deadline  = '0;

    logic                  o_cfg_ready;
    logic                  busy;
    logic                  o_valid;
    logic [1:0]            o_kind;
    logic [SLOT_W-1:0]     o_task_slot;
    logic [PRIO_W-1:0]     o_priority_res;
    logic [KEY_W-1:0]      o_sort_key;
    logic                  o_priority_error;
    logic                  o_table_full;
    logic                  o_last;

    fixed_priority_assigner_core #(
        .MAX_TASKS (N_TASKS),
        .TICK_BITS (KEY_W)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_period         (i_period),
        .i_deadline       (i_deadline),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_task_slot      (o_task_slot),
        .o_priority_res   (o_priority_res),
        .o_sort_key       (o_sort_key),
        .o_priority_error (o_priority_error),
        .o_table_full     (o_table_full),
        .o_last           (o_last)
    );

    // ------------------------------------------------------------------------
    // priority calculator: private copy of the task table and registers
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0]   tbl_period   [N_TASKS];
    logic [KEY_W-1:0]   tbl_deadline [N_TASKS];
    logic [N_TASKS-1:0] tbl_done     = '0;
    int                 tbl_count    = 0;
    logic [KEY_W-1:0]   calc_prev_key = '0;
    logic [PRIO_W-1:0]  calc_prio     = '0;
    logic               reg_policy    = POLICY_RST;
    logic [PRIO_W-1:0]  reg_top       = TOP_PRIO_RST;

    t_prio_result awaited_q [$];    // results still due from the block
    t_prio_result step_q    [$];    // results of the command just accepted

    int errors        = 0;
    int items_sent    = 0;
    int cfg_writes    = 0;
    int results_seen  = 0;
    int refused_adds  = 0;
    int idle_prios    = 0;
    int empty_assigns = 0;
    int send_idle_pct = 0;
    int stall_count   = 0;

    t_plan_row plan [$];

    function automatic t_prio_result mk_res(input logic [1:0] kind, input int slot,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic [KEY_W-1:0] key,
                                            input logic perr, input logic full,
                                            input logic last);
        t_prio_result r;
        r.kind = kind;
        r.slot = SLOT_W'(slot);
        r.prio = prio;
        r.key  = key;
        r.perr = perr;
        r.full = full;
        r.last = last;
        return r;
    endfunction

    // keys drawn so that ties, zero and all ones show up often
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(3))
            0: return KEY_W'($urandom_range(7));
            1: return ($urandom_range(1) == 0) ? '0 : KEY_MAX;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // works out what one accepted command yields and updates the table copy
    task automatic calc_command(input logic [1:0] func, input logic [KEY_W-1:0] per,
                                input logic [KEY_W-1:0] dl);
        int               n;
        int               pick;
        logic [KEY_W-1:0] best;
        logic [KEY_W-1:0] key;
        step_q.delete();
        case (func)
            FUNC_ADD: begin
                if (tbl_count >= N_TASKS) begin
                    step_q.push_back(mk_res(KIND_ADD_ACK, 0, '0, '0, 1'b0, 1'b1, 1'b1));
                end else begin
                    tbl_period[tbl_count]   = per;
                    tbl_deadline[tbl_count] = dl;
                    tbl_done[tbl_count]     = 1'b0;
                    step_q.push_back(mk_res(KIND_ADD_ACK, tbl_count, '0, '0,
                                            1'b0, 1'b0, 1'b1));
                    tbl_count++;
                end
            end
            FUNC_ASSIGN: begin
                n = tbl_count;
                if (n == 0) begin
                    step_q.push_back(mk_res(KIND_EMPTY, 0, '0, '0, 1'b0, 1'b0, 1'b1));
                end else begin
                    // marks cleared on every assign, so all tasks are redone
                    tbl_done      = '0;
                    calc_prev_key = '0;
                    calc_prio     = reg_top;
                    for (int it = 0; it < n; it++) begin
                        best = KEY_MAX;
                        pick = 0;
                        // less-or-equal: the highest slot wins a tie
                        for (int s = 0; s < n; s++) begin
                            if (!tbl_done[s]) begin
                                key = reg_policy ? tbl_deadline[s] : tbl_period[s];
                                if (key <= best) begin
                                    best = key;
                                    pick = s;
                                end
                            end
                        end
                        // step down only on a new key, and never below idle
                        if (best != calc_prev_key && calc_prio > 0)
                            calc_prio--;
                        tbl_done[pick] = 1'b1;
                        calc_prev_key  = best;
                        step_q.push_back(mk_res(KIND_ASSIGN, pick, calc_prio, best,
                                                calc_prio == 0, 1'b0, it == n - 1));
                    end
                end
            end
            FUNC_CLEAR: begin
                tbl_count = 0;
                tbl_done  = '0;
            end
            default: ;  // unused code, nothing happens
        endcase
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // one command transfer; start is left high so a following command can go
    // straight on, and every pause below lowers it first
    task automatic issue(input logic [1:0] func, input logic [KEY_W-1:0] per,
                         input logic [KEY_W-1:0] dl, input logic typed,
                         input t_prio_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_func     <= func;
        i_period   <= per;
        i_deadline <= dl;
        do @(posedge i_clk); while (busy);
        calc_command(func, per, dl);
        if (typed)
            awaited_q.push_back(want);
        else
            foreach (step_q[j]) awaited_q.push_back(step_q[j]);
        items_sent++;
    endtask

    // stop sending and wait until every due result is in and the block is free
    task automatic drain(input int settle);
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_q.size() != 0 || busy);
        repeat (settle) @(posedge i_clk);
    endtask

    // register writes only ever happen with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain(SETTLE_CYCLES);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_POLICY)
            reg_policy = val[0];
        else if (idx == CFG_TOP_PRIO)
            reg_top = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_plan_row cmd_row(input logic [1:0] func, input logic [KEY_W-1:0] per,
                                          input logic [KEY_W-1:0] dl, input int reps,
                                          input logic rnd);
        t_plan_row r;
        r          = '0;
        r.kind     = ROW_CMD;
        r.func     = func;
        r.period   = per;
        r.deadline = dl;
        r.reps     = 6'(reps);
        r.rnd_keys = rnd;
        return r;
    endfunction

    function automatic t_plan_row typed_row(input logic [1:0] func, input logic [KEY_W-1:0] per,
                                            input logic [KEY_W-1:0] dl, input t_prio_result want);
        t_plan_row r;
        r       = cmd_row(func, per, dl, 1, 1'b0);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // random commands: mostly a clear, a handful of adds, then one or two assigns, else one random code
    task automatic run_phase(input int idle_pct, input int budget);
        int stop_at;
        int seq;
        int reps;
        send_idle_pct = idle_pct;
        stop_at       = items_sent + budget;
        seq           = 0;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                if ($urandom_range(99) < 80)
                    issue(FUNC_CLEAR, rand_key(), rand_key(), 1'b0, '0);
                // small tables most of the time, now and then up to two adds past full
                reps = ($urandom_range(9) == 0) ? $urandom_range(N_TASKS - 2, N_TASKS + 2)
                                                : $urandom_range(1, 6);
                for (int k = 0; k < reps; k++)
                    issue(FUNC_ADD, rand_key(), rand_key(), 1'b0, '0);
                issue(FUNC_ASSIGN, rand_key(), rand_key(), 1'b0, '0);
                if ($urandom_range(99) < 20)
                    issue(FUNC_ASSIGN, rand_key(), rand_key(), 1'b0, '0);
                seq++;
                // sender holds back until the block has answered everything
                if (seq % 4 == 0)
                    drain(0);
            end else begin
                issue(2'($urandom_range(3)), rand_key(), rand_key(), 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking, sampled at the rising edge
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input logic [KEY_W-1:0] want,
                                input logic [KEY_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_prio_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_table_full === 1'b1) refused_adds++;
            if (o_priority_error === 1'b1) idle_prios++;
            if (o_kind === KIND_EMPTY) empty_assigns++;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result, kind %h slot %h priority %h key %h",
                         $time, o_kind, o_task_slot, o_priority_res, o_sort_key);
                errors++;
            end else begin
                want = awaited_q.pop_front();
                report_field("kind", KEY_W'(want.kind), KEY_W'(o_kind));
                report_field("task_slot", KEY_W'(want.slot), KEY_W'(o_task_slot));
                report_field("priority_res", KEY_W'(want.prio), KEY_W'(o_priority_res));
                report_field("sort_key", want.key, o_sort_key);
                report_field("priority_error", KEY_W'(want.perr), KEY_W'(o_priority_error));
                report_field("table_full", KEY_W'(want.full), KEY_W'(o_table_full));
                report_field("last", KEY_W'(want.last), KEY_W'(o_last));
            end
        end
    end

    // watchdog: any command, result or register transfer resets the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] per;
        logic [KEY_W-1:0] dl;
        int               idle_pct [4];
        int               top_pick;

        // directed table; typed rows hold the answer straight from the spec
        plan.push_back(typed_row(FUNC_ASSIGN, '0, '0,
                                 mk_res(KIND_EMPTY, 0, '0, '0, 1'b0, 1'b0, 1'b1)));
        plan.push_back(cmd_row(FUNC_UNUSED, KEY_MAX, KEY_MAX, 1, 1'b0));
        plan.push_back(typed_row(FUNC_ADD, '0, KEY_MAX,
                                 mk_res(KIND_ADD_ACK, 0, '0, '0, 1'b0, 1'b0, 1'b1)));
        plan.push_back(typed_row(FUNC_ADD, KEY_MAX, '0,
                                 mk_res(KIND_ADD_ACK, 1, '0, '0, 1'b0, 1'b0, 1'b1)));
        plan.push_back(typed_row(FUNC_ADD, KEY_W'(5), KEY_W'(5),
                                 mk_res(KIND_ADD_ACK, 2, '0, '0, 1'b0, 1'b0, 1'b1)));
        plan.push_back(typed_row(FUNC_ADD, KEY_W'(5), KEY_W'(7),
                                 mk_res(KIND_ADD_ACK, 3, '0, '0, 1'b0, 1'b0, 1'b1)));
        // period order; the zero key ties with the start value and keeps the top
        plan.push_back(cmd_row(FUNC_ASSIGN, '0, '0, 1, 1'b0));
        plan.push_back(cfg_row(CFG_POLICY, CFG_DATA_W'(1)));
        // second assign on the same table, now by deadline
        plan.push_back(cmd_row(FUNC_ASSIGN, '0, '0, 1, 1'b0));
        plan.push_back(cmd_row(FUNC_CLEAR, KEY_MAX, KEY_MAX, 1, 1'b0));
        plan.push_back(typed_row(FUNC_ASSIGN, KEY_MAX, KEY_MAX,
                                 mk_res(KIND_EMPTY, 0, '0, '0, 1'b0, 1'b0, 1'b1)));
        plan.push_back(cfg_row(CFG_TOP_PRIO, CFG_DATA_W'(1)));
        plan.push_back(cmd_row(FUNC_ADD, '0, '0, N_TASKS, 1'b1));
        // one add past a full table is refused
        plan.push_back(typed_row(FUNC_ADD, KEY_MAX, KEY_MAX,
                                 mk_res(KIND_ADD_ACK, 0, '0, '0, 1'b0, 1'b1, 1'b1)));
        // lowest top priority: most tasks end up flagged at idle
        plan.push_back(cmd_row(FUNC_ASSIGN, '0, '0, 1, 1'b0));
        plan.push_back(cfg_row(CFG_TOP_PRIO, CFG_DATA_W'(255)));
        plan.push_back(cfg_row(CFG_POLICY, CFG_DATA_W'(0)));
        plan.push_back(cmd_row(FUNC_ASSIGN, '0, '0, 1, 1'b0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                cfg_write(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                for (int k = 0; k < plan[r].reps; k++) begin
                    per = plan[r].rnd_keys ? rand_key() : plan[r].period;
                    dl  = plan[r].rnd_keys ? rand_key() : plan[r].deadline;
                    issue(plan[r].func, per, dl, plan[r].typed, plan[r].want);
                end
            end
        end

        // random phases: no gaps, sender idle half the time, no gaps again
        // (results cannot be held off), then sparse gaps
        idle_pct = '{0, 50, 0, 15};
        foreach (idle_pct[p]) begin
            cfg_write(CFG_POLICY, CFG_DATA_W'($urandom_range(1)));
            case ($urandom_range(3))
                0: top_pick = 1;
                1: top_pick = 255;
                2: top_pick = $urandom_range(2, 4);
                default: top_pick = $urandom_range(1, 255);
            endcase
            cfg_write(CFG_TOP_PRIO, CFG_DATA_W'(top_pick));
            run_phase(idle_pct[p], RANDOM_ITEMS / 4);
        end

        drain(TAIL_CYCLES);

        $display("run covered %0d commands, %0d results, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("refused adds %0d, empty assigns %0d, priorities at idle %0d",
                 refused_adds, empty_assigns, idle_prios);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/fpa_pkg.sv
rtl/fpa_ram.sv
rtl/fixed_priority_assigner_core.sv
bench/fixed_priority_assigner_core_test.sv
